@@ hw/rtl/hse_pkg.sv @@
package hse_pkg;

  localparam int unsigned NumKeyWords = 8;
  localparam int unsigned KeyWidth    = 64;

  typedef logic [31:0] word_t;

  typedef word_t hash_t [8];

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;
  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenFill  = 6'd56;

  // Control between the byte sequencer and the compression core.
  typedef struct packed {
    logic start;     // begin compressing the 16 buffered words
    logic init_cv;   // load chaining value with initial hash
  } core_ctl_t;

endpackage

@@ hw/rtl/hse_stream_if.sv @@
interface hse_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/hmac_sha256_engine_top.sv @@
// SHA-256 / HMAC-SHA256 engine. Message words enter big-endian with 0..4
// valid bytes; mode is sampled on a message's first item. One digest item
// leaves after the item marked last. Bytes are packed into the round unit's
// 16-word window one byte per cycle while the round unit is idle; each full
// block runs 64 rounds on a single round unit, one round per cycle, then
// updates the chaining value, and input is held off meanwhile. Each item is
// accepted, then its valid bytes are loaded one at a time. Closing a message
// loads the padding and length bytes and runs one or two blocks. HMAC mode
// adds a 64-byte ipad key block at message start and, at the end, an outer
// pass of the opad key block and the inner digest. The digest item waits
// on the output until taken; no new message is accepted meanwhile. Key words
// are written through the plain write port; the user must write them only
// while idle, as the block itself does not enforce it.
module hmac_sha256_engine_top
  import hse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  hse_stream_if.sink   in_ch,
  hse_stream_if.source out_ch
);

  // in payload: {mode, data_word, byte_count, last} = 37 bits
  logic        in_mode, in_last;
  word_t       in_word;
  logic [2:0]  in_cnt;
  assign {in_mode, in_word, in_cnt, in_last} = in_ch.payload;

  logic [KeyWidth-1:0] key [NumKeyWords];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumKeyWords; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  typedef enum logic [3:0] {
    S_IDLE, S_KEY, S_MSG, S_WAIT_IN, S_PAD, S_ZERO, S_LEN, S_SWAP, S_INNER, S_OUT
  } state_t;

  state_t      state, in_state, msg_state;
  logic        hmac, outer, lastf;
  word_t       word;
  logic [2:0]  cnt, in_cnt_c, bidx;
  logic [5:0]  fill, kidx;
  logic [63:0] bitlen;
  logic [23:0] part;
  word_t       inner [8];
  logic [7:0]  byte_v;
  logic        put, msg_put, acc, wr_en;
  word_t       wr_word;
  core_ctl_t   ctl;
  logic        busy;
  word_t       cv [8];
  logic [255:0] dig;

  hse_core u_core (
    .clk, .rst, .ctl,
    .wr_en, .wr_idx(fill[5:2]), .wr_word,
    .busy, .cv
  );

  // Byte source for the current state.
  logic [63:0] kw;
  always_comb begin
    kw = key[kidx[5:3]];
    byte_v = 8'h00;
    unique case (state)
      S_KEY:   byte_v = 8'(kw >> (7'd56 - {kidx[2:0], 3'b000}))
                      ^ (outer ? OpadByte : IpadByte);
      S_MSG:   byte_v = 8'(word >> (6'd24 - {bidx[1:0], 3'b000}));
      S_PAD:   byte_v = PadByte;
      S_LEN:   byte_v = 8'(bitlen >> (7'd56 - {kidx[2:0], 3'b000}));
      S_INNER: byte_v = 8'(inner[kidx[4:2]] >> (6'd24 - {kidx[1:0], 3'b000}));
      default: byte_v = 8'h00;
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE || state == S_WAIT_IN) && !busy;
  assign out_ch.valid = (state == S_OUT) && !busy;
  always_comb begin
    for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = cv[i];
  end
  assign out_ch.payload = dig;

  assign acc = in_ch.valid && in_ch.ready;

  // Counts above four mean four.
  assign in_cnt_c = (in_cnt > 3'd4) ? 3'd4 : in_cnt;

  // Where a word goes once taken: bytes to load, or straight on.
  always_comb begin
    if (in_cnt_c == 3'd0) in_state = in_last ? S_PAD : S_WAIT_IN;
    else                  in_state = S_MSG;
    if (cnt == 3'd0) msg_state = lastf ? S_PAD : S_WAIT_IN;
    else             msg_state = S_MSG;
  end

  // One byte into the window per cycle while the round unit is idle.
  assign put = !busy && (state == S_KEY || state == S_MSG || state == S_PAD ||
                         state == S_ZERO || state == S_LEN || state == S_INNER);
  // Key, message and inner digest bytes count toward the bit length.
  assign msg_put = put && (state == S_KEY || state == S_MSG || state == S_INNER);

  // The fourth byte of a word completes it; the 64th byte starts the block.
  assign wr_en   = put && (fill[1:0] == 2'd3);
  assign wr_word = {part, byte_v};

  always_comb begin
    ctl.start   = put && (fill == 6'd63);
    ctl.init_cv = (state == S_IDLE && acc) || (state == S_SWAP && !busy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      hmac   <= 1'b0;
      outer  <= 1'b0;
      lastf  <= 1'b0;
      word   <= '0;
      cnt    <= '0;
      bidx   <= '0;
      fill   <= '0;
      kidx   <= '0;
      bitlen <= '0;
      part   <= '0;
      for (int i = 0; i < 8; i++) inner[i] <= '0;
    end else begin
      if (put) begin
        fill <= fill + 6'd1;
        part <= {part[15:0], byte_v};
      end
      if (msg_put) bitlen <= bitlen + 64'd8;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            hmac   <= in_mode;
            outer  <= 1'b0;
            bitlen <= '0;
            word   <= in_word;
            cnt    <= in_cnt_c;
            lastf  <= in_last;
            bidx   <= '0;
            kidx   <= '0;
            state  <= in_mode ? S_KEY : in_state;
          end
        end
        S_WAIT_IN: begin
          if (acc) begin
            word  <= in_word;
            cnt   <= in_cnt_c;
            lastf <= in_last;
            bidx  <= '0;
            state <= in_state;
          end
        end
        S_KEY: begin
          if (put) begin
            kidx <= kidx + 6'd1;
            if (kidx == 6'd63) state <= outer ? S_INNER : msg_state;
          end
        end
        S_MSG: begin
          if (put) begin
            bidx <= bidx + 3'd1;
            if (bidx == cnt - 3'd1) state <= lastf ? S_PAD : S_WAIT_IN;
          end
        end
        S_PAD: begin
          if (put) state <= (fill == LenFill - 6'd1) ? S_LEN : S_ZERO;
        end
        S_ZERO: begin
          if (put && fill == LenFill - 6'd1) state <= S_LEN;
        end
        S_LEN: begin
          if (put) begin
            if (kidx[2:0] == 3'd7) begin
              kidx  <= '0;
              state <= (hmac && !outer) ? S_SWAP : S_OUT;
            end else begin
              kidx <= kidx + 6'd1;
            end
          end
        end
        S_SWAP: begin
          // inner digest final: keep it and restart for the outer pass
          if (!busy) begin
            inner  <= cv;
            outer  <= 1'b1;
            bitlen <= '0;
            state  <= S_KEY;
          end
        end
        S_INNER: begin
          if (put) begin
            if (kidx == 6'd31) begin
              kidx  <= '0;
              state <= S_PAD;
            end else begin
              kidx <= kidx + 6'd1;
            end
          end
        end
        S_OUT: begin
          if (out_ch.valid && out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/hse_core.sv @@
module hse_core
  import hse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  core_ctl_t ctl,
  input  logic      wr_en,
  input  logic [3:0] wr_idx,
  input  word_t     wr_word,
  output logic      busy,
  output word_t     cv [8]
);

  word_t w [16];
  word_t v [8];
  logic [5:0] rnd;
  logic       run;
  logic       fin;

  function automatic word_t ror(input word_t x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  word_t x15, x2, wt, wnew, t1, t2, s0, s1;

  always_comb begin
    x15  = w[4'(rnd + 6'd1)];
    x2   = w[4'(rnd + 6'd14)];
    s0   = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
    s1   = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
    wnew = w[rnd[3:0]] + s0 + w[4'(rnd + 6'd9)] + s1;
    wt   = rnd[5:4] == 2'd0 ? w[rnd[3:0]] : wnew;
    t1   = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + wt;
    t2   = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Busy through the 64 rounds and the fold of the round state into cv
  assign busy = run | fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      rnd <= '0;
      for (int i = 0; i < 8; i++) begin
        cv[i] <= init_h(3'(i));
        v[i]  <= '0;
      end
    end else begin
      if (ctl.init_cv) begin
        for (int i = 0; i < 8; i++) cv[i] <= init_h(3'(i));
      end
      if (ctl.start) begin
        run <= 1'b1;
        rnd <= '0;
        for (int i = 0; i < 8; i++) v[i] <= cv[i];
      end else if (run) begin
        w[rnd[3:0]] <= wt;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin <= 1'b0;
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] + v[i];
      end
      if (wr_en) w[wr_idx] <= wr_word;
    end
  end

endmodule
